FILE: hdl/ptrc_pkg.sv
// Shared types and constants of the point-triangle region classifier.
`timescale 1ns / 1ps

package ptrc_pkg;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned PIPE_DEPTH = 6;

  typedef enum logic [2:0] {
    REGION_CORNER0  = 3'd0,
    REGION_CORNER1  = 3'd1,
    REGION_CORNER2  = 3'd2,
    REGION_EDGE01   = 3'd3,
    REGION_EDGE12   = 3'd4,
    REGION_EDGE20   = 3'd5,
    REGION_INTERIOR = 3'd6
  } region_e;

  // Per corner i: le_dn[i] is dot(P-Ti, Tnext-Ti) <= 0,
  // le_dp[i] is dot(P-Ti, Tprev-Ti) <= 0.
  typedef struct packed {
    logic [2:0] le_dn;
    logic [2:0] le_dp;
  } dot_flags_t;

endpackage

FILE: hdl/ptrc_dot3.sv
// Two-stage pipelined three-term signed dot product.
`timescale 1ns / 1ps

module ptrc_dot3 #(
  parameter int unsigned IN_BITS = 25
) (
  input  logic                          clk_i,
  input  logic signed [IN_BITS-1:0]     a_i [3],
  input  logic signed [IN_BITS-1:0]     b_i [3],
  output logic signed [2*IN_BITS+1:0]   dot_o
);

  localparam int unsigned PROD_BITS = 2 * IN_BITS;
  localparam int unsigned SUM_BITS  = 2 * IN_BITS + 2;

  logic signed [PROD_BITS-1:0] prod_d [3];
  logic signed [PROD_BITS-1:0] prod_q [3];
  logic signed [SUM_BITS-1:0]  ext    [3];
  logic signed [SUM_BITS-1:0]  dot_d;
  logic signed [SUM_BITS-1:0]  dot_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = PROD_BITS'(a_i[k]) * PROD_BITS'(b_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // sign-extend each product before the sum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ext[k] = SUM_BITS'(prod_q[k]);
    end
    dot_d = ext[0] + ext[1] + ext[2];
  end

  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
  end

  assign dot_o = dot_q;

endmodule

FILE: hdl/ptrc_wide_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
`timescale 1ns / 1ps

module ptrc_wide_mul #(
  parameter int unsigned OP_BITS = 52
) (
  input  logic                          clk_i,
  input  logic signed [OP_BITS-1:0]     a_i,
  input  logic signed [OP_BITS-1:0]     b_i,
  output logic signed [2*OP_BITS-1:0]   prod_o
);

  localparam int unsigned LO_BITS   = OP_BITS / 2;
  localparam int unsigned HI_BITS   = OP_BITS - LO_BITS;
  localparam int unsigned PROD_BITS = 2 * OP_BITS;

  logic signed [HI_BITS-1:0]   a_hi, b_hi;
  logic signed [LO_BITS:0]     a_lo, b_lo;
  logic signed [2*HI_BITS-1:0] hh_d, hh_q;
  logic signed [OP_BITS:0]     hl_d, hl_q;
  logic signed [OP_BITS:0]     lh_d, lh_q;
  logic [2*LO_BITS-1:0]        ll_d, ll_q;
  logic signed [PROD_BITS-1:0] hh_x, hl_x, lh_x;
  logic [PROD_BITS-1:0]        ll_x;
  logic [PROD_BITS-1:0]        prod_d;
  logic [PROD_BITS-1:0]        prod_q;

  // split: high halves signed, low halves unsigned (zero bit on top)
  assign a_hi = a_i[OP_BITS-1:LO_BITS];
  assign b_hi = b_i[OP_BITS-1:LO_BITS];
  assign a_lo = $signed({1'b0, a_i[LO_BITS-1:0]});
  assign b_lo = $signed({1'b0, b_i[LO_BITS-1:0]});

  assign hh_d = (2*HI_BITS)'(a_hi) * (2*HI_BITS)'(b_hi);
  assign hl_d = (OP_BITS+1)'(a_hi) * (OP_BITS+1)'(b_lo);
  assign lh_d = (OP_BITS+1)'(a_lo) * (OP_BITS+1)'(b_hi);
  assign ll_d = (2*LO_BITS)'(a_i[LO_BITS-1:0]) * (2*LO_BITS)'(b_i[LO_BITS-1:0]);

  always_ff @(posedge clk_i) begin
    hh_q <= hh_d;
    hl_q <= hl_d;
    lh_q <= lh_d;
    ll_q <= ll_d;
  end

  always_comb begin
    hh_x   = PROD_BITS'(hh_q);
    hl_x   = PROD_BITS'(hl_q);
    lh_x   = PROD_BITS'(lh_q);
    ll_x   = PROD_BITS'(ll_q);
    prod_d = (PROD_BITS'(hh_x) << (2 * LO_BITS))
           + (PROD_BITS'(hl_x + lh_x) << LO_BITS)
           + ll_x;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = $signed(prod_q);

endmodule

FILE: hdl/point_triangle_region_classify_top.sv
// Top level of the point-triangle closest-feature classifier.
`timescale 1ns / 1ps

// Classifies a query point against a triangle: reports the closest corner,
// edge or the interior, using exact signs of integer dot products and of
// cross-dot-cross terms, so no rounding ever changes a decision. A request
// is taken at every clock edge where start is high; busy never rises, so a
// new request may follow in each cycle. Each request yields exactly one
// result, shown on region_code_o for a single cycle with valid_o high. The
// receiver cannot hold results off and must take each one as it appears.
// Throughput is one request per cycle; the pipeline stages are the edge
// differences, coordinate products, dot-product sums, partial products of
// the wide cross-dot-cross multiply, their recombination, and the final
// signed compare with the region decision.
module point_triangle_region_classify_top
  import ptrc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] corner0_x_i,
  input  logic signed [COORD_BITS-1:0] corner0_y_i,
  input  logic signed [COORD_BITS-1:0] corner0_z_i,
  input  logic signed [COORD_BITS-1:0] corner1_x_i,
  input  logic signed [COORD_BITS-1:0] corner1_y_i,
  input  logic signed [COORD_BITS-1:0] corner1_z_i,
  input  logic signed [COORD_BITS-1:0] corner2_x_i,
  input  logic signed [COORD_BITS-1:0] corner2_y_i,
  input  logic signed [COORD_BITS-1:0] corner2_z_i,
  output logic                         valid_o,
  output logic [2:0]                   region_code_o
);

  localparam int unsigned DIFF_BITS = COORD_BITS + 1;
  localparam int unsigned DOT_BITS  = 2 * DIFF_BITS + 2;
  localparam int unsigned CDC_BITS  = 2 * DOT_BITS;

  // index 0 is the point, 1..3 are corners 0..2
  logic signed [COORD_BITS-1:0] pt [4][3];

  // per corner i: point minus corner, next corner minus corner,
  // previous corner minus corner
  logic signed [DIFF_BITS-1:0] pv_d [3][3];
  logic signed [DIFF_BITS-1:0] nx_d [3][3];
  logic signed [DIFF_BITS-1:0] pr_d [3][3];
  logic signed [DIFF_BITS-1:0] pv_q [3][3];
  logic signed [DIFF_BITS-1:0] nx_q [3][3];
  logic signed [DIFF_BITS-1:0] pr_q [3][3];

  logic signed [DOT_BITS-1:0] dn [3];   // (P-Ti).(Tnext-Ti)
  logic signed [DOT_BITS-1:0] dp [3];   // (P-Ti).(Tprev-Ti)
  logic signed [DOT_BITS-1:0] ab [3];   // (Tnext-Ti).(Tprev-Ti)
  logic signed [DOT_BITS-1:0] aa [3];   // |Tnext-Ti|^2

  logic signed [CDC_BITS-1:0] lhs [3];
  logic signed [CDC_BITS-1:0] rhs [3];

  dot_flags_t flags_d, flags_s4_q, flags_s5_q;
  logic [2:0] cdc_ge;
  region_e    region_d, region_q;

  logic [PIPE_DEPTH-1:0] vld_d, vld_q;
  logic                  accept;

  function automatic logic signed [DIFF_BITS-1:0] sext(
    input logic signed [COORD_BITS-1:0] v
  );
    return $signed({v[COORD_BITS-1], v});
  endfunction

  assign pt[0][0] = point_x_i;
  assign pt[0][1] = point_y_i;
  assign pt[0][2] = point_z_i;
  assign pt[1][0] = corner0_x_i;
  assign pt[1][1] = corner0_y_i;
  assign pt[1][2] = corner0_z_i;
  assign pt[2][0] = corner1_x_i;
  assign pt[2][1] = corner1_y_i;
  assign pt[2][2] = corner1_z_i;
  assign pt[3][0] = corner2_x_i;
  assign pt[3][1] = corner2_y_i;
  assign pt[3][2] = corner2_z_i;

  // The pipeline never stalls, so a request is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: form all edge and point differences.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pv_d[i][k] = sext(pt[0][k]) - sext(pt[i+1][k]);
        nx_d[i][k] = sext(pt[((i + 1) % 3) + 1][k]) - sext(pt[i+1][k]);
        pr_d[i][k] = sext(pt[((i + 2) % 3) + 1][k]) - sext(pt[i+1][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= pv_d;
    nx_q <= nx_d;
    pr_q <= pr_d;
  end

  // Stages 2-3: the twelve dot products, four per corner.
  for (genvar gi = 0; gi < 3; gi++) begin : g_corner
    ptrc_dot3 #(.IN_BITS(DIFF_BITS)) u_dot_dn (
      .clk_i (clk_i),
      .a_i   (pv_q[gi]),
      .b_i   (nx_q[gi]),
      .dot_o (dn[gi])
    );
    ptrc_dot3 #(.IN_BITS(DIFF_BITS)) u_dot_dp (
      .clk_i (clk_i),
      .a_i   (pv_q[gi]),
      .b_i   (pr_q[gi]),
      .dot_o (dp[gi])
    );
    ptrc_dot3 #(.IN_BITS(DIFF_BITS)) u_dot_ab (
      .clk_i (clk_i),
      .a_i   (nx_q[gi]),
      .b_i   (pr_q[gi]),
      .dot_o (ab[gi])
    );
    ptrc_dot3 #(.IN_BITS(DIFF_BITS)) u_dot_aa (
      .clk_i (clk_i),
      .a_i   (nx_q[gi]),
      .b_i   (nx_q[gi]),
      .dot_o (aa[gi])
    );

    // Stages 4-5: cross-dot-cross for edge i -> i+1 is
    // dn*ab - aa*dp; compute both products exactly.
    ptrc_wide_mul #(.OP_BITS(DOT_BITS)) u_mul_lhs (
      .clk_i  (clk_i),
      .a_i    (dn[gi]),
      .b_i    (ab[gi]),
      .prod_o (lhs[gi])
    );
    ptrc_wide_mul #(.OP_BITS(DOT_BITS)) u_mul_rhs (
      .clk_i  (clk_i),
      .a_i    (aa[gi]),
      .b_i    (dp[gi]),
      .prod_o (rhs[gi])
    );
  end

  // Reduce the dot products to their sign tests; a zero counts as <= 0.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      flags_d.le_dn[i] = dn[i][DOT_BITS-1] || (dn[i] == '0);
      flags_d.le_dp[i] = dp[i][DOT_BITS-1] || (dp[i] == '0);
    end
  end

  // Hold the sign flags alongside the wide multiply stages.
  always_ff @(posedge clk_i) begin
    flags_s4_q <= flags_d;
    flags_s5_q <= flags_s4_q;
  end

  // Stage 6: exact compare and the decision, first match wins.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cdc_ge[i] = lhs[i] >= rhs[i];
    end
    if (flags_s5_q.le_dn[0] && flags_s5_q.le_dp[0]) begin
      region_d = REGION_CORNER0;
    end else if (flags_s5_q.le_dn[1] && flags_s5_q.le_dp[1]) begin
      region_d = REGION_CORNER1;
    end else if (flags_s5_q.le_dn[2] && flags_s5_q.le_dp[2]) begin
      region_d = REGION_CORNER2;
    end else if (cdc_ge[0] && !flags_s5_q.le_dn[0] && !flags_s5_q.le_dp[1]) begin
      region_d = REGION_EDGE01;
    end else if (cdc_ge[1] && !flags_s5_q.le_dn[1] && !flags_s5_q.le_dp[2]) begin
      region_d = REGION_EDGE12;
    end else if (cdc_ge[2] && !flags_s5_q.le_dn[2] && !flags_s5_q.le_dp[0]) begin
      region_d = REGION_EDGE20;
    end else begin
      region_d = REGION_INTERIOR;
    end
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
  end

  // Advance the valid bits in step with the data.
  assign vld_d = {vld_q[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign valid_o       = vld_q[PIPE_DEPTH-1];
  assign region_code_o = region_q;

  // Every accepted request yields a result.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_DEPTH valid_o)
    else $error("accepted request produced no result");

  // No result appears without a request behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##PIPE_DEPTH !valid_o)
    else $error("result strobe without a request");

  // A point lying on corner 0 must be classified as corner 0.
  a_point_on_corner0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && point_x_i == corner0_x_i && point_y_i == corner0_y_i &&
     point_z_i == corner0_z_i)
    |-> ##PIPE_DEPTH (region_code_o == REGION_CORNER0))
    else $error("point on corner 0 not reported as corner 0");

endmodule

FILE: sim/tb_point_triangle_region_classify_top.sv
// Self-checking testbench of the point-triangle closest-feature classifier.
`timescale 1ns / 1ps

// Feeds query requests (point plus three corners) to the classifier. The
// expected region of each one is worked out with exact wide integer math
// and compared, in order, with the strobed results. A short directed set
// covers the coordinate extremes, every region, zero-sign ties and
// degenerate triangles. Random requests follow in three phases: back to
// back, sender idle 60% of the time, and sender idle 25% of the time.
// The receiver side has no stall to model, since results cannot be held off.
module tb_point_triangle_region_classify_top;
  import ptrc_pkg::*;

  localparam int CB          = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAXC        = 8388607;
  localparam int MINC        = -8388608;
  localparam int RAND_PER_PHASE = 500;

  // Slots of a request: the query point first, then corners 0..2.
  localparam int PT_P  = 0;
  localparam int PT_T0 = 1;
  localparam int PT_T1 = 2;
  localparam int PT_T2 = 3;

  // Coordinate k*3+i is axis i (x, y, z) of point slot k.
  typedef logic [11:0][CB-1:0] query_t;
  // Wide enough for the products of the cross-dot-cross terms.
  typedef logic signed [159:0] wide_t;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       start_r = 1'b0;
  query_t     req_r = '0;
  logic       busy;
  logic       valid_o;
  logic [2:0] region_code_o;

  query_t  pending_q[$];
  region_e region_q[$];
  region_e want_region;
  int      idle_pct = 0;
  int      queued_cnt = 0;
  int      accepted_cnt = 0;
  int      fail_cnt = 0;
  int      cycle_cnt = 0;
  int      region_hits[7];

  always #5 clk_i = ~clk_i;

  point_triangle_region_classify_top #(
    .COORD_BITS(CB)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .start        (start_r),
    .busy         (busy),
    .point_x_i    (req_r[0]),
    .point_y_i    (req_r[1]),
    .point_z_i    (req_r[2]),
    .corner0_x_i  (req_r[3]),
    .corner0_y_i  (req_r[4]),
    .corner0_z_i  (req_r[5]),
    .corner1_x_i  (req_r[6]),
    .corner1_y_i  (req_r[7]),
    .corner1_z_i  (req_r[8]),
    .corner2_x_i  (req_r[9]),
    .corner2_y_i  (req_r[10]),
    .corner2_z_i  (req_r[11]),
    .valid_o      (valid_o),
    .region_code_o(region_code_o)
  );

  // ---------------------------------------------------------------------
  // Region predictor: exact signed arithmetic, no rounding anywhere.
  // ---------------------------------------------------------------------
  function automatic wide_t pt_coord(query_t q, int k, int i);
    wide_t w;
    w = wide_t'($signed(q[k*3+i]));
    return w;
  endfunction

  // dot(Pa - Po, Pb - Po)
  function automatic wide_t dot_of(query_t q, int o, int a, int b);
    wide_t s;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      s += (pt_coord(q, a, i) - pt_coord(q, o, i)) * (pt_coord(q, b, i) - pt_coord(q, o, i));
    end
    return s;
  endfunction

  // dot(cross(Pa-Po, Pb-Po), cross(Pd-Po, Pa-Po)) >= 0, expanded into
  // (a.c)(a.b) - (a.a)(b.c) with a=Pa-Po, b=Pb-Po, c=Pd-Po.
  function automatic bit cross_term_nonneg(query_t q, int o, int a, int b, int d);
    wide_t lhs, rhs;
    lhs = dot_of(q, o, a, d) * dot_of(q, o, a, b);
    rhs = dot_of(q, o, a, a) * dot_of(q, o, b, d);
    return lhs >= rhs;
  endfunction

  // Closest feature; first match wins: corners, then edges, then interior.
  function automatic region_e closest_region(query_t q);
    wide_t d01, d02, d12, d10, d20, d21;
    d01 = dot_of(q, PT_T0, PT_P, PT_T1);
    d02 = dot_of(q, PT_T0, PT_P, PT_T2);
    d12 = dot_of(q, PT_T1, PT_P, PT_T2);
    d10 = dot_of(q, PT_T1, PT_P, PT_T0);
    d20 = dot_of(q, PT_T2, PT_P, PT_T0);
    d21 = dot_of(q, PT_T2, PT_P, PT_T1);
    if (d01 <= 0 && d02 <= 0) return REGION_CORNER0;
    if (d12 <= 0 && d10 <= 0) return REGION_CORNER1;
    if (d20 <= 0 && d21 <= 0) return REGION_CORNER2;
    if (cross_term_nonneg(q, PT_T0, PT_T1, PT_T2, PT_P) && d01 > 0 && d10 > 0)
      return REGION_EDGE01;
    if (cross_term_nonneg(q, PT_T1, PT_T2, PT_T0, PT_P) && d12 > 0 && d21 > 0)
      return REGION_EDGE12;
    if (cross_term_nonneg(q, PT_T2, PT_T0, PT_T1, PT_P) && d20 > 0 && d02 > 0)
      return REGION_EDGE20;
    return REGION_INTERIOR;
  endfunction

  // ---------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------
  task automatic queue_request(input int px, py, pz, ax, ay, az,
                               bx, by, bz, cx, cy, cz);
    query_t q;
    q[0] = CB'(px);  q[1] = CB'(py);  q[2] = CB'(pz);
    q[3] = CB'(ax);  q[4] = CB'(ay);  q[5] = CB'(az);
    q[6] = CB'(bx);  q[7] = CB'(by);  q[8] = CB'(bz);
    q[9] = CB'(cx);  q[10] = CB'(cy); q[11] = CB'(cz);
    pending_q.push_back(q);
    queued_cnt++;
  endtask

  // Mix of full-range noise, tiny coordinates (lots of ties and degenerate
  // shapes), points placed around a random triangle, and shared corners.
  task automatic queue_random_request();
    query_t q;
    int     t[3][3];
    int     e1, e2, a, b, pick, src, dst;
    pick = $urandom_range(99);
    if (pick < 25 || pick >= 85) begin
      for (int j = 0; j < 12; j++) q[j] = CB'($urandom());
      if (pick >= 85) begin
        // copy one point slot onto another
        src = $urandom_range(3);
        dst = (src + 1 + $urandom_range(2)) % 4;
        for (int i = 0; i < 3; i++) q[dst*3+i] = q[src*3+i];
      end
    end else if (pick < 45) begin
      for (int j = 0; j < 12; j++) q[j] = CB'(int'($urandom_range(16)) - 8);
    end else begin
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < 3; i++)
          t[k][i] = int'($urandom_range(2097152)) - 1048576;
      a = int'($urandom_range(32)) - 8;
      b = int'($urandom_range(32)) - 8;
      for (int i = 0; i < 3; i++) begin
        e1 = t[1][i] - t[0][i];
        e2 = t[2][i] - t[0][i];
        q[i] = CB'(t[0][i] + (a * e1 + b * e2) / 16 + int'($urandom_range(2048)) - 1024);
        for (int k = 0; k < 3; k++) q[(k+1)*3+i] = CB'(t[k][i]);
      end
    end
    pending_q.push_back(q);
    queued_cnt++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: hold a request until taken, then advance or idle at random.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      start_r <= 1'b0;
      req_r   <= '0;
    end else if (!start_r || !busy) begin
      if (start_r) begin
        region_q.push_back(closest_region(req_r));
        accepted_cnt++;
      end
      if (pending_q.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
        req_r   <= pending_q.pop_front();
        start_r <= 1'b1;
      end else begin
        start_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobe must match the oldest outstanding prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_n && valid_o !== 1'b0) begin
      if (region_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, expected none, got valid=%b region=%0d",
                 $time, valid_o, region_code_o);
      end else begin
        want_region = region_q.pop_front();
        region_hits[want_region]++;
        if (valid_o !== 1'b1 || region_code_o !== want_region) begin
          fail_cnt++;
          $display("%0t: region_code mismatch, expected %0d (%s), got %0d (valid=%b)",
                   $time, want_region, want_region.name(), region_code_o, valid_o);
        end
      end
    end
  end

  // Watchdog: a hung block must not hang the run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests taken of %0d, %0d results open",
               cycle_cnt, accepted_cnt, queued_cnt, region_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed requests, then the random phases.
  // ---------------------------------------------------------------------
  initial begin
    int idle_phase[3];
    idle_phase[0] = 0;
    idle_phase[1] = 60;
    idle_phase[2] = 25;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // origin and both coordinate extremes
    queue_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_request(MAXC, MAXC, MAXC, MINC, MINC, MINC,
                  MAXC, MINC, MINC, MINC, MAXC, MINC);
    queue_request(MINC, MINC, MINC, MAXC, MAXC, MAXC,
                  MINC, MAXC, MAXC, MAXC, MINC, MAXC);
    // every region of a small right triangle in the z=0 plane
    queue_request(-10, -10, 5, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(1100, -10, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(-10, 1100, 3, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(500, -50, 7, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(600, 600, -9, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(-50, 500, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(200, 200, 100, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    // zero dot products on the corner boundaries
    queue_request(0, -5, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(1000, -5, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    // zero cross-dot-cross term: point lying on an edge
    queue_request(500, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    queue_request(500, 500, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    // point on a corner
    queue_request(0, 1000, 0, 0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    // degenerate triangles: coincident, collinear, all corners equal
    queue_request(50, 50, 50, 5, 5, 5, 5, 5, 5, 100, 0, 0);
    queue_request(10, -3, 7, 0, 0, 0, 10, 10, 10, 20, 20, 20);
    queue_request(MAXC, MINC, 0, 7, -7, 7, 7, -7, 7, 7, -7, 7);
    // full-scale triangle, points far off the plane and around it
    queue_request(0, 0, MAXC, MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0);
    queue_request(0, 0, MINC, MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0);
    queue_request(0, MINC, MINC, MINC, MINC + 1, 0, MAXC, MINC + 1, 0, 0, MAXC, 0);
    queue_request(MAXC, MAXC, MAXC, MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0);
    queue_request(MINC, MAXC, 0, MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = idle_phase[ph];
      for (int n = 0; n < RAND_PER_PHASE; n++) queue_random_request();
      while (accepted_cnt != queued_cnt) @(negedge clk_i);
    end

    // drain the pipeline, then watch a little longer for stray strobes
    while (region_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);

    if (region_q.size() != 0) begin
      fail_cnt += region_q.size();
      $display("%0t: %0d results never arrived", $time, region_q.size());
    end
    $display("Checked %0d requests: directed extremes, ties, degenerate shapes, random mix.",
             accepted_cnt);
    $display("Regions seen: c0=%0d c1=%0d c2=%0d e01=%0d e12=%0d e20=%0d in=%0d, %0d failures",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3],
             region_hits[4], region_hits[5], region_hits[6], fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
